FILE: rtl/core/tbg_pkg.sv
package tbg_pkg;

  localparam int WORD_W      = 48;
  localparam int FRAC_W      = 24;
  localparam int HALF_W      = WORD_W / 2;
  localparam int PROD_W      = 2 * WORD_W;
  localparam int EXT_W       = PROD_W + 1;
  localparam int MASS_W      = 16;
  localparam int DT_W        = 24;
  localparam int NBODY       = 3;
  localparam int BODY_W      = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 24;
  localparam int RQ          = 30;
  localparam int RSQRT_ITERS = 6;
  localparam int ITER_W      = 3;
  localparam int LEN_W       = $clog2(WORD_W + 1);
  localparam int SCALE_K     = FRAC_W + FRAC_W / 2 - RQ;
  localparam int PP_LAST     = 3;

  localparam logic [MASS_W-1:0] MASS_RESET = MASS_W'(75);
  localparam logic [DT_W-1:0]   DT_RESET   = DT_W'(167772);

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [WORD_W-1:0]        mag_t;

  localparam word_t WMAX       = {1'b0, {(WORD_W-1){1'b1}}};
  localparam word_t WMIN       = {1'b1, {(WORD_W-1){1'b0}}};
  localparam word_t THREE_HALF = word_t'(3) <<< (RQ - 1);

  // Value with its overflow flag.
  typedef struct packed {
    logic  sat;
    word_t val;
  } res_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MASS_FIRST  = 2'd0,
    CFG_MASS_SECOND = 2'd1,
    CFG_MASS_THIRD  = 2'd2,
    CFG_TIME_STEP   = 2'd3
  } cfg_reg_t;

  localparam logic MODE_TICK = 1'b1;

  // How a raw product is scaled back into a word.
  typedef enum logic [2:0] {
    SHK_NONE,
    SHK_FRAC,
    SHK_HALF,
    SHK_RAW30,
    SHK_RAW31
  } shk_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DT2, S_PI, S_DIFF, S_DXX, S_DYY, S_NORM, S_Y2, S_H, S_Y,
    S_RFIN, S_TX1, S_TX2, S_TX3, S_TY1, S_TY2, S_TY3, S_MX, S_MY, S_NEXT,
    S_UVX, S_UAX, S_UDX, S_UVY, S_UAY, S_UDY, S_DONE
  } state_t;

  function automatic res_t sat_add(input word_t a, input word_t b);
    logic [WORD_W:0] s;
    res_t r;
    s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
    r.sat = s[WORD_W] ^ s[WORD_W-1];
    r.val = r.sat ? (s[WORD_W] ? WMIN : WMAX) : word_t'(s[WORD_W-1:0]);
    return r;
  endfunction

  function automatic res_t sat_sub(input word_t a, input word_t b);
    logic [WORD_W:0] s;
    res_t r;
    s = {a[WORD_W-1], a} - {b[WORD_W-1], b};
    r.sat = s[WORD_W] ^ s[WORD_W-1];
    r.val = r.sat ? (s[WORD_W] ? WMIN : WMAX) : word_t'(s[WORD_W-1:0]);
    return r;
  endfunction

  // Scales a magnitude product back, rounding half away from zero for the
  // fraction kinds and truncating for the raw kinds, then signs the others.
  function automatic res_t mul_post(input logic [PROD_W-1:0] prod, input logic neg,
                                    input shk_t kind);
    logic [EXT_W-1:0] ext;
    logic [EXT_W-1:0] m;
    res_t r;
    ext   = {1'b0, prod};
    r.sat = 1'b0;
    r.val = '0;
    case (kind)
      SHK_NONE:  m = ext;
      SHK_FRAC:  m = (ext + (EXT_W'(1) << (FRAC_W - 1))) >> FRAC_W;
      SHK_HALF:  m = (ext + (EXT_W'(1) << FRAC_W)) >> (FRAC_W + 1);
      SHK_RAW30: m = ext >> RQ;
      SHK_RAW31: m = ext >> (RQ + 1);
      default:   m = ext;
    endcase
    if (kind == SHK_RAW30 || kind == SHK_RAW31) begin
      r.val = word_t'(m[WORD_W-1:0]);
    end else if (!neg) begin
      if (m > EXT_W'(mag_t'(WMAX))) begin
        r.sat = 1'b1;
        r.val = WMAX;
      end else begin
        r.val = word_t'(m[WORD_W-1:0]);
      end
    end else begin
      if (m > EXT_W'(mag_t'(WMIN))) begin
        r.sat = 1'b1;
        r.val = WMIN;
      end else begin
        r.val = word_t'(~m[WORD_W-1:0] + 1'b1);
      end
    end
    return r;
  endfunction

  // Mantissa of the squared distance in Q0.30, taken at an even bit length.
  function automatic mag_t norm_mant(input mag_t r2, input logic [LEN_W-1:0] len);
    mag_t x;
    if (len > LEN_W'(RQ)) begin
      x = r2 >> (len - LEN_W'(RQ));
    end else begin
      x = r2 << (LEN_W'(RQ) - len);
    end
    return x;
  endfunction

  // Brings the Q2.30 reciprocal root back to the word format.
  function automatic mag_t rsqrt_scale(input mag_t y, input logic [LEN_W-1:0] len);
    logic [LEN_W-2:0] half;
    mag_t r;
    half = len[LEN_W-1:1];
    if (half <= (LEN_W-1)'(SCALE_K)) begin
      r = y << ((LEN_W-1)'(SCALE_K) - half);
    end else begin
      r = (y + (mag_t'(1) << (half - (LEN_W-1)'(SCALE_K + 1))))
          >> (half - (LEN_W-1)'(SCALE_K));
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/tbg_mul.sv
module tbg_mul import tbg_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  mag_t              a_mag,
  input  mag_t              b_mag,
  output logic              busy,
  output logic              done,
  output logic [PROD_W-1:0] prod
);

  // Four half-word partial products, one per cycle, into one accumulator.
  mag_t               a_r, b_r;
  logic [PROD_W-1:0]  acc_r;
  logic [1:0]         step_r;
  logic               run_r, done_r;
  logic [HALF_W-1:0]  a_part, b_part;
  mag_t               pp;
  logic [PROD_W-1:0]  pp_ext;

  always_comb begin
    a_part = step_r[1] ? a_r[WORD_W-1:HALF_W] : a_r[HALF_W-1:0];
    b_part = step_r[0] ? b_r[WORD_W-1:HALF_W] : b_r[HALF_W-1:0];
    pp     = a_part * b_part;
    pp_ext = (PROD_W'(pp) << (step_r[1] ? HALF_W : 0)) << (step_r[0] ? HALF_W : 0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        a_r    <= a_mag;
        b_r    <= b_mag;
        acc_r  <= '0;
        step_r <= '0;
        run_r  <= 1'b1;
      end else if (run_r) begin
        acc_r  <= acc_r + pp_ext;
        step_r <= step_r + 2'd1;
        if (step_r == 2'(PP_LAST)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy = run_r;
  assign done = done_r;
  assign prod = acc_r;

endmodule

FILE: rtl/core/three_body_gravity_step_unit.sv
// Channel   Direction  Handshake              Payload
// in_*      in         start and not busy     in_mode, in_body, four load values
// out_*     out        out_valid, one cycle   six positions, out_singular
// cfg_*     in         cfg_we                 cfg_index, cfg_wdata
//
// A load request is written into the body state as it is taken and leaves busy low.
// A tick request holds busy while it runs up to 187 multiplies (31 when all pairs
// coincide) on one shared multiplier, each made of a start step, four half-word
// partial products and a done step, plus a normalisation and four steps without
// a multiply for each of the six pairs that does not coincide.
// The result is shown for the single cycle in which out_valid is high; the
// receiver cannot stall it, and busy drops in the cycle after.
// Synchronous active-low reset clears the body state to zero and the
// registers to their default masses and time step.
module three_body_gravity_step_unit import tbg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_mode,
  input  logic [BODY_W-1:0]     in_body,
  input  logic signed [47:0]    in_load_pos_x,
  input  logic signed [47:0]    in_load_pos_y,
  input  logic signed [47:0]    in_load_vel_x,
  input  logic signed [47:0]    in_load_vel_y,
  output logic                  out_valid,
  output logic signed [47:0]    out_first_x,
  output logic signed [47:0]    out_first_y,
  output logic signed [47:0]    out_second_x,
  output logic signed [47:0]    out_second_y,
  output logic signed [47:0]    out_third_x,
  output logic signed [47:0]    out_third_y,
  output logic                  out_singular,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  state_t state_r, state_nxt;

  // Body state: one entry per body, read at a selected body; a tick also copies all positions out.
  word_t pos_x_r [NBODY];
  word_t pos_y_r [NBODY];
  word_t vel_x_r [NBODY];
  word_t vel_y_r [NBODY];
  word_t ax_r    [NBODY];
  word_t ay_r    [NBODY];

  logic [MASS_W-1:0] mass_first_r, mass_second_r, mass_third_r;
  logic [DT_W-1:0]   time_step_r;

  // Working registers of the pair loop and the update.
  logic [BODY_W-1:0] i_r, j_r;
  word_t             pix_r, piy_r, dx_r, dy_r, hold_r, r2_r, tx_r, ty_r, dt2_r;
  mag_t              tmp_r, x_r, y_r, y2_r, t_r, r_r;
  logic [LEN_W-1:0]  len_r;
  logic [ITER_W-1:0] it_r;
  logic              sat_r;
  word_t             o_fx_r, o_fy_r, o_sx_r, o_sy_r, o_tx_r, o_ty_r;

  // Shared multiplier and its operand selection.
  word_t             op_a, op_b;
  shk_t              op_kind;
  logic              is_mul, mul_start, mul_busy, mul_done, op_neg;
  mag_t              a_mag, b_mag;
  logic [PROD_W-1:0] mul_prod;
  logic [BODY_W-1:0] rd_sel;

  word_t rd_px, rd_py, rd_vx, rd_vy, ax_i, ay_i, dt_w, mass_j;
  res_t  post, sum1, dxn, dyn, posx_new, posy_new, velx_new, vely_new, axn, ayn;
  word_t t_val;
  logic  last_pair_i, tick_acc, load_acc;

  assign tick_acc = start && !busy && (in_mode == MODE_TICK);
  assign load_acc = start && !busy && (in_mode != MODE_TICK) && (in_body < BODY_W'(NBODY));

  assign rd_px  = pos_x_r[rd_sel];
  assign rd_py  = pos_y_r[rd_sel];
  assign rd_vx  = vel_x_r[rd_sel];
  assign rd_vy  = vel_y_r[rd_sel];
  assign ax_i   = ax_r[i_r];
  assign ay_i   = ay_r[i_r];
  assign dt_w   = {{(WORD_W-DT_W){1'b0}}, time_step_r};

  always_comb begin
    case (j_r)
      2'd0:    mass_j = {{(WORD_W-MASS_W){1'b0}}, mass_first_r};
      2'd1:    mass_j = {{(WORD_W-MASS_W){1'b0}}, mass_second_r};
      default: mass_j = {{(WORD_W-MASS_W){1'b0}}, mass_third_r};
    endcase
  end

  // Operand selection and handshake outputs for each state.
  always_comb begin
    op_a      = '0;
    op_b      = '0;
    op_kind   = SHK_FRAC;
    is_mul    = 1'b0;
    rd_sel    = i_r;
    busy      = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      S_IDLE: busy = 1'b0;
      S_DT2: begin
        is_mul = 1'b1; op_a = dt_w; op_b = dt_w;
      end
      S_DIFF: rd_sel = j_r;
      S_DXX: begin
        is_mul = 1'b1; op_a = dx_r; op_b = dx_r;
      end
      S_DYY: begin
        is_mul = 1'b1; op_a = dy_r; op_b = dy_r;
      end
      S_Y2: begin
        is_mul = 1'b1; op_a = word_t'(y_r); op_b = word_t'(y_r); op_kind = SHK_RAW30;
      end
      S_H: begin
        is_mul = 1'b1; op_a = word_t'(x_r); op_b = word_t'(y2_r); op_kind = SHK_RAW31;
      end
      S_Y: begin
        is_mul = 1'b1; op_a = word_t'(y_r); op_b = word_t'(t_r); op_kind = SHK_RAW30;
      end
      S_TX1: begin
        is_mul = 1'b1; op_a = dx_r; op_b = word_t'(r_r);
      end
      S_TX2, S_TX3: begin
        is_mul = 1'b1; op_a = tx_r; op_b = word_t'(r_r);
      end
      S_TY1: begin
        is_mul = 1'b1; op_a = dy_r; op_b = word_t'(r_r);
      end
      S_TY2, S_TY3: begin
        is_mul = 1'b1; op_a = ty_r; op_b = word_t'(r_r);
      end
      S_MX: begin
        is_mul = 1'b1; op_a = tx_r; op_b = mass_j; op_kind = SHK_NONE;
      end
      S_MY: begin
        is_mul = 1'b1; op_a = ty_r; op_b = mass_j; op_kind = SHK_NONE;
      end
      S_UVX: begin
        is_mul = 1'b1; op_a = rd_vx; op_b = dt_w;
      end
      S_UAX: begin
        is_mul = 1'b1; op_a = ax_i; op_b = dt2_r; op_kind = SHK_HALF;
      end
      S_UDX: begin
        is_mul = 1'b1; op_a = ax_i; op_b = dt_w;
      end
      S_UVY: begin
        is_mul = 1'b1; op_a = rd_vy; op_b = dt_w;
      end
      S_UAY: begin
        is_mul = 1'b1; op_a = ay_i; op_b = dt2_r; op_kind = SHK_HALF;
      end
      S_UDY: begin
        is_mul = 1'b1; op_a = ay_i; op_b = dt_w;
      end
      S_DONE: out_valid = 1'b1;
      default: ;
    endcase
  end

  assign a_mag     = op_a[WORD_W-1] ? mag_t'(-op_a) : mag_t'(op_a);
  assign b_mag     = op_b[WORD_W-1] ? mag_t'(-op_b) : mag_t'(op_b);
  assign op_neg    = op_a[WORD_W-1] ^ op_b[WORD_W-1];
  assign mul_start = is_mul && !mul_busy && !mul_done;

  tbg_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a_mag (a_mag),
    .b_mag (b_mag),
    .busy  (mul_busy),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  // Post-processing of the product and the saturating adders around it.
  assign post     = mul_post(mul_prod, op_neg, op_kind);
  assign sum1     = sat_add(hold_r, post.val);
  assign dxn      = sat_sub(pix_r, rd_px);
  assign dyn      = sat_sub(piy_r, rd_py);
  assign posx_new = sat_add(rd_px, sum1.val);
  assign posy_new = sat_add(rd_py, sum1.val);
  assign velx_new = sat_add(rd_vx, post.val);
  assign vely_new = sat_add(rd_vy, post.val);
  assign axn      = sat_sub(ax_i, post.val);
  assign ayn      = sat_sub(ay_i, post.val);
  assign t_val    = (post.val >= THREE_HALF) ? word_t'(0) : THREE_HALF - post.val;

  // The last partner of body i: body two pairs with bodies zero and one only.
  assign last_pair_i = (i_r == 2'd2) ? (j_r == 2'd1) : (j_r == 2'd2);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (tick_acc) state_nxt = S_DT2;
      S_DT2:   if (mul_done) state_nxt = S_PI;
      S_PI:    state_nxt = S_DIFF;
      S_DIFF:  state_nxt = S_DXX;
      S_DXX:   if (mul_done) state_nxt = S_DYY;
      S_DYY: begin
        if (mul_done) state_nxt = (sum1.val == '0) ? S_NEXT : S_NORM;
      end
      S_NORM:  if (tmp_r == '0) state_nxt = S_Y2;
      S_Y2:    if (mul_done) state_nxt = S_H;
      S_H:     if (mul_done) state_nxt = S_Y;
      S_Y: begin
        if (mul_done) state_nxt = (it_r == ITER_W'(RSQRT_ITERS - 1)) ? S_RFIN : S_Y2;
      end
      S_RFIN:  state_nxt = S_TX1;
      S_TX1:   if (mul_done) state_nxt = S_TX2;
      S_TX2:   if (mul_done) state_nxt = S_TX3;
      S_TX3:   if (mul_done) state_nxt = S_TY1;
      S_TY1:   if (mul_done) state_nxt = S_TY2;
      S_TY2:   if (mul_done) state_nxt = S_TY3;
      S_TY3:   if (mul_done) state_nxt = S_MX;
      S_MX:    if (mul_done) state_nxt = S_MY;
      S_MY:    if (mul_done) state_nxt = S_NEXT;
      S_NEXT:  state_nxt = (last_pair_i && i_r == 2'd2) ? S_UVX : S_PI;
      S_UVX:   if (mul_done) state_nxt = S_UAX;
      S_UAX:   if (mul_done) state_nxt = S_UDX;
      S_UDX:   if (mul_done) state_nxt = S_UVY;
      S_UVY:   if (mul_done) state_nxt = S_UAY;
      S_UAY:   if (mul_done) state_nxt = S_UDY;
      S_UDY: begin
        if (mul_done) state_nxt = (i_r == 2'd2) ? S_DONE : S_UVX;
      end
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      mass_first_r  <= MASS_RESET;
      mass_second_r <= MASS_RESET;
      mass_third_r  <= MASS_RESET;
      time_step_r   <= DT_RESET;
      sat_r         <= 1'b0;
      i_r           <= '0;
      j_r           <= '0;
      it_r          <= '0;
      len_r         <= '0;
      for (int b = 0; b < NBODY; b++) begin
        pos_x_r[b] <= '0;
        pos_y_r[b] <= '0;
        vel_x_r[b] <= '0;
        vel_y_r[b] <= '0;
      end
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_MASS_FIRST:  mass_first_r  <= cfg_wdata[MASS_W-1:0];
          CFG_MASS_SECOND: mass_second_r <= cfg_wdata[MASS_W-1:0];
          CFG_MASS_THIRD:  mass_third_r  <= cfg_wdata[MASS_W-1:0];
          CFG_TIME_STEP:   time_step_r   <= cfg_wdata[DT_W-1:0];
          default: ;
        endcase
      end

      if (load_acc) begin
        pos_x_r[in_body] <= in_load_pos_x;
        pos_y_r[in_body] <= in_load_pos_y;
        vel_x_r[in_body] <= in_load_vel_x;
        vel_y_r[in_body] <= in_load_vel_y;
      end

      case (state_r)
        S_IDLE: begin
          if (tick_acc) begin
            // Positions are reported as they stand before the step.
            o_fx_r <= pos_x_r[0];
            o_fy_r <= pos_y_r[0];
            o_sx_r <= pos_x_r[1];
            o_sy_r <= pos_y_r[1];
            o_tx_r <= pos_x_r[2];
            o_ty_r <= pos_y_r[2];
            sat_r  <= 1'b0;
            i_r    <= 2'd0;
            j_r    <= 2'd1;
            for (int b = 0; b < NBODY; b++) begin
              ax_r[b] <= '0;
              ay_r[b] <= '0;
            end
          end
        end
        S_DT2: if (mul_done) dt2_r <= post.val;
        S_PI: begin
          pix_r <= rd_px;
          piy_r <= rd_py;
        end
        S_DIFF: begin
          dx_r  <= dxn.val;
          dy_r  <= dyn.val;
          sat_r <= sat_r | dxn.sat | dyn.sat;
        end
        S_DXX: begin
          if (mul_done) begin
            hold_r <= post.val;
            sat_r  <= sat_r | post.sat;
          end
        end
        S_DYY: begin
          if (mul_done) begin
            // A zero squared distance drops the pair and flags the step.
            r2_r  <= sum1.val;
            tmp_r <= mag_t'(sum1.val);
            len_r <= '0;
            sat_r <= sat_r | post.sat | sum1.sat | (sum1.val == '0);
          end
        end
        S_NORM: begin
          // Two bits a cycle, so the bit length comes out even.
          if (tmp_r != '0) begin
            tmp_r <= tmp_r >> 2;
            len_r <= len_r + LEN_W'(2);
          end else begin
            x_r  <= norm_mant(mag_t'(r2_r), len_r);
            y_r  <= mag_t'(THREE_HALF);
            it_r <= '0;
          end
        end
        S_Y2: if (mul_done) y2_r <= mag_t'(post.val);
        S_H:  if (mul_done) t_r <= mag_t'(t_val);
        S_Y: begin
          if (mul_done) begin
            y_r  <= mag_t'(post.val);
            it_r <= it_r + ITER_W'(1);
          end
        end
        S_RFIN: r_r <= rsqrt_scale(y_r, len_r);
        S_TX1, S_TX2, S_TX3: begin
          if (mul_done) begin
            tx_r  <= post.val;
            sat_r <= sat_r | post.sat;
          end
        end
        S_TY1, S_TY2, S_TY3: begin
          if (mul_done) begin
            ty_r  <= post.val;
            sat_r <= sat_r | post.sat;
          end
        end
        S_MX: begin
          if (mul_done) begin
            ax_r[i_r] <= axn.val;
            sat_r     <= sat_r | post.sat | axn.sat;
          end
        end
        S_MY: begin
          if (mul_done) begin
            ay_r[i_r] <= ayn.val;
            sat_r     <= sat_r | post.sat | ayn.sat;
          end
        end
        S_NEXT: begin
          if (last_pair_i) begin
            i_r <= (i_r == 2'd2) ? 2'd0 : i_r + 2'd1;
            j_r <= 2'd0;
          end else begin
            j_r <= (j_r + 2'd1 == i_r) ? j_r + 2'd2 : j_r + 2'd1;
          end
        end
        S_UVX, S_UVY: begin
          if (mul_done) begin
            hold_r <= post.val;
            sat_r  <= sat_r | post.sat;
          end
        end
        S_UAX: begin
          if (mul_done) begin
            pos_x_r[i_r] <= posx_new.val;
            sat_r        <= sat_r | post.sat | sum1.sat | posx_new.sat;
          end
        end
        S_UAY: begin
          if (mul_done) begin
            pos_y_r[i_r] <= posy_new.val;
            sat_r        <= sat_r | post.sat | sum1.sat | posy_new.sat;
          end
        end
        S_UDX: begin
          if (mul_done) begin
            vel_x_r[i_r] <= velx_new.val;
            sat_r        <= sat_r | post.sat | velx_new.sat;
          end
        end
        S_UDY: begin
          if (mul_done) begin
            vel_y_r[i_r] <= vely_new.val;
            sat_r        <= sat_r | post.sat | vely_new.sat;
            i_r          <= (i_r == 2'd2) ? 2'd0 : i_r + 2'd1;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_first_x  = o_fx_r;
  assign out_first_y  = o_fy_r;
  assign out_second_x = o_sx_r;
  assign out_second_y = o_sy_r;
  assign out_third_x  = o_tx_r;
  assign out_third_y  = o_ty_r;
  assign out_singular = sat_r;

  // The result strobe lasts a single cycle.
  assert property (@(posedge clk) disable iff (!rst_n) out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // The sequencer never moves on while a multiply is still running.
  assert property (@(posedge clk) disable iff (!rst_n) mul_busy |=> $stable(state_r))
    else $error("state changed during a multiply");

  // A finished product always lands in a state that consumes it.
  assert property (@(posedge clk) disable iff (!rst_n) mul_done |-> is_mul)
    else $error("product finished outside a multiply state");

  // A tick request raises busy, a load request does not.
  assert property (@(posedge clk) disable iff (!rst_n)
                   (start && !busy) |=> (busy == $past(in_mode)))
    else $error("busy does not follow the accepted request");

endmodule

FILE: dv/testbench.sv
module testbench import tbg_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  // Run length guard, set well above the run time of about 400 requests, at
  // most one result each, with sender gaps.
  localparam int CYCLE_LIMIT = 3000000;
  localparam longint WMAX_L = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint WMIN_L = -WMAX_L - 1;
  localparam longint UNIT = 64'sd1 << FRAC_W;

  typedef struct {
    logic              mode;
    logic [BODY_W-1:0] body;
    logic [47:0]       pos_x, pos_y, vel_x, vel_y;
  } body_req_t;

  typedef struct {
    logic [47:0] first_x, first_y, second_x, second_y, third_x, third_y;
    logic        singular;
  } snapshot_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_mode = 1'b0;
  logic [BODY_W-1:0] in_body = '0;
  logic signed [47:0] in_load_pos_x = '0, in_load_pos_y = '0;
  logic signed [47:0] in_load_vel_x = '0, in_load_vel_y = '0;
  logic out_valid;
  logic signed [47:0] out_first_x, out_first_y, out_second_x, out_second_y;
  logic signed [47:0] out_third_x, out_third_y;
  logic out_singular;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  three_body_gravity_step_unit dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  body_req_t pending_reqs[$];
  snapshot_t expected_snaps[$];
  int        error_count = 0;
  int        sender_idle_pct = 0;
  int        cycle_count = 0;
  logic      req_taken = 1'b0;

  // Shadow copy of the block: the body state and the register file.
  longint pos_x[NBODY], pos_y[NBODY], vel_x[NBODY], vel_y[NBODY];
  longint mass[NBODY];
  longint step_dt;
  bit     step_sat;

  function automatic longint clamp_word(longint v);
    if (v > WMAX_L) begin
      step_sat = 1'b1;
      return WMAX_L;
    end
    if (v < WMIN_L) begin
      step_sat = 1'b1;
      return WMIN_L;
    end
    return v;
  endfunction

  // Fixed-point product shifted right by sh, rounded half away from zero,
  // then saturated to the word range.
  function automatic longint fx_mul(longint a, longint b, int sh);
    logic [63:0]  ma, mb;
    logic [127:0] p;
    logic         neg;
    ma  = a < 0 ? -a : a;
    mb  = b < 0 ? -b : b;
    neg = (a < 0) != (b < 0);
    p   = 128'(ma) * 128'(mb);
    if (sh > 0) p = (p + (128'(1) << (sh - 1))) >> sh;
    if (!neg) begin
      if (p > 128'(WMAX_L)) begin
        step_sat = 1'b1;
        return WMAX_L;
      end
      return longint'(p[63:0]);
    end
    if (p > 128'(WMAX_L) + 1) begin
      step_sat = 1'b1;
      return WMIN_L;
    end
    return -longint'(p[63:0]);
  endfunction

  // Reciprocal square root: mantissa normalised at an even exponent, then
  // six Newton steps in Q2.30 with truncation, then scaled back.
  function automatic longint inv_sqrt(longint r2);
    logic [63:0] big_r, x, y, y2, h, t, three_half;
    int len, e, sh, i;
    big_r = r2;
    three_half = 64'd3 << (RQ - 1);
    len = 0;
    while (len < 64 && (big_r >> len) != 0) len++;
    if ((len + 64 - FRAC_W) % 2 != 0) len++;
    e = len - FRAC_W;
    x = len > RQ ? big_r >> (len - RQ) : big_r << (RQ - len);
    y = three_half;
    for (i = 0; i < RSQRT_ITERS; i++) begin
      y2 = (y * y) >> RQ;
      h  = ((x * y2) >> RQ) >> 1;
      t  = h >= three_half ? 64'd0 : three_half - h;
      y  = (y * t) >> RQ;
    end
    sh = FRAC_W - RQ - e / 2;
    if (sh >= 0) begin
      if (sh > 31) begin
        step_sat = 1'b1;
        return WMAX_L;
      end
      y = y << sh;
    end else begin
      sh = -sh;
      if (sh >= 63) return 0;
      y = (y + (64'd1 << (sh - 1))) >> sh;
    end
    if (y > 64'(WMAX_L)) begin
      step_sat = 1'b1;
      return WMAX_L;
    end
    return longint'(y);
  endfunction

  // Applies one request to the shadow state; a tick yields a snapshot.
  function automatic bit advance_bodies(body_req_t rq, output snapshot_t snap);
    longint acc_x[NBODY], acc_y[NBODY];
    longint dx, dy, r2, r, tx, ty, dt2;
    int b;
    if (rq.mode != MODE_TICK) begin
      // Body index three names no body, so the load is dropped.
      if (rq.body < NBODY) begin
        b = rq.body;
        pos_x[b] = longint'($signed(rq.pos_x));
        pos_y[b] = longint'($signed(rq.pos_y));
        vel_x[b] = longint'($signed(rq.vel_x));
        vel_y[b] = longint'($signed(rq.vel_y));
      end
      return 1'b0;
    end
    step_sat = 1'b0;
    snap.first_x  = pos_x[0][47:0];
    snap.first_y  = pos_y[0][47:0];
    snap.second_x = pos_x[1][47:0];
    snap.second_y = pos_y[1][47:0];
    snap.third_x  = pos_x[2][47:0];
    snap.third_y  = pos_y[2][47:0];
    for (int i = 0; i < NBODY; i++) begin
      acc_x[i] = 0;
      acc_y[i] = 0;
      for (int j = 0; j < NBODY; j++) begin
        if (j == i) continue;
        dx = clamp_word(pos_x[i] - pos_x[j]);
        dy = clamp_word(pos_y[i] - pos_y[j]);
        r2 = clamp_word(fx_mul(dx, dx, FRAC_W) + fx_mul(dy, dy, FRAC_W));
        if (r2 <= 0) begin
          // Coincident bodies: the pair adds nothing but is flagged.
          step_sat = 1'b1;
          continue;
        end
        r  = inv_sqrt(r2);
        tx = fx_mul(fx_mul(fx_mul(dx, r, FRAC_W), r, FRAC_W), r, FRAC_W);
        ty = fx_mul(fx_mul(fx_mul(dy, r, FRAC_W), r, FRAC_W), r, FRAC_W);
        acc_x[i] = clamp_word(acc_x[i] - fx_mul(tx, mass[j], 0));
        acc_y[i] = clamp_word(acc_y[i] - fx_mul(ty, mass[j], 0));
      end
    end
    dt2 = (step_dt * step_dt + (64'sd1 << (DT_W - 1))) >>> DT_W;
    for (int i = 0; i < NBODY; i++) begin
      pos_x[i] = clamp_word(pos_x[i] + clamp_word(fx_mul(vel_x[i], step_dt, DT_W)
                 + fx_mul(acc_x[i], dt2, DT_W + 1)));
      pos_y[i] = clamp_word(pos_y[i] + clamp_word(fx_mul(vel_y[i], step_dt, DT_W)
                 + fx_mul(acc_y[i], dt2, DT_W + 1)));
      vel_x[i] = clamp_word(vel_x[i] + fx_mul(acc_x[i], step_dt, DT_W));
      vel_y[i] = clamp_word(vel_y[i] + fx_mul(acc_y[i], step_dt, DT_W));
    end
    snap.singular = step_sat;
    return 1'b1;
  endfunction

  task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Driver: a new request goes up on the falling edge after the previous one
  // was taken, unless the sender chooses to idle this cycle.
  always @(negedge clk) begin
    body_req_t rq;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || req_taken) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
        rq = pending_reqs.pop_front();
        in_mode       <= rq.mode;
        in_body       <= rq.body;
        in_load_pos_x <= rq.pos_x;
        in_load_pos_y <= rq.pos_y;
        in_load_vel_x <= rq.vel_x;
        in_load_vel_y <= rq.vel_y;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: results are checked before an accepted request is predicted,
  // though the block never shows both on the same edge.
  always @(posedge clk) begin
    body_req_t rq;
    snapshot_t got, want;
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else if (rst_n) begin
      if (out_valid) begin
        if (expected_snaps.size() == 0) begin
          $display("unexpected result at %0t", $realtime);
          error_count++;
        end else begin
          want = expected_snaps.pop_front();
          if (out_first_x !== want.first_x)
            report_mismatch("first_x", out_first_x, want.first_x);
          if (out_first_y !== want.first_y)
            report_mismatch("first_y", out_first_y, want.first_y);
          if (out_second_x !== want.second_x)
            report_mismatch("second_x", out_second_x, want.second_x);
          if (out_second_y !== want.second_y)
            report_mismatch("second_y", out_second_y, want.second_y);
          if (out_third_x !== want.third_x)
            report_mismatch("third_x", out_third_x, want.third_x);
          if (out_third_y !== want.third_y)
            report_mismatch("third_y", out_third_y, want.third_y);
          if (out_singular !== want.singular)
            report_mismatch("singular", 48'(out_singular), 48'(want.singular));
        end
      end
      req_taken <= start && !busy;
      if (start && !busy) begin
        rq.mode  = in_mode;
        rq.body  = in_body;
        rq.pos_x = in_load_pos_x;
        rq.pos_y = in_load_pos_y;
        rq.vel_x = in_load_vel_x;
        rq.vel_y = in_load_vel_y;
        if (advance_bodies(rq, got)) expected_snaps.push_back(got);
      end
    end
  end

  task automatic queue_load(int b, longint px, longint py, longint vx, longint vy);
    body_req_t rq;
    rq.mode  = ~MODE_TICK;
    rq.body  = b[BODY_W-1:0];
    rq.pos_x = px[47:0];
    rq.pos_y = py[47:0];
    rq.vel_x = vx[47:0];
    rq.vel_y = vy[47:0];
    pending_reqs.push_back(rq);
  endtask

  task automatic queue_tick();
    body_req_t rq;
    rq.mode  = MODE_TICK;
    rq.body  = BODY_W'($urandom_range(3));
    rq.pos_x = 48'({$urandom, $urandom});
    rq.pos_y = 48'({$urandom, $urandom});
    rq.vel_x = 48'({$urandom, $urandom});
    rq.vel_y = 48'({$urandom, $urandom});
    pending_reqs.push_back(rq);
  endtask

  // Mostly a few units around the origin, where orbits are meaningful; now and
  // then a full-range word or an extreme to drive saturation.
  function automatic longint pick_value(bit wide);
    logic [47:0] w;
    int sel;
    sel = $urandom_range(99);
    if (wide && sel < 10) begin
      w = 48'({$urandom, $urandom});
      return longint'($signed(w));
    end
    if (wide && sel < 14) begin
      case ($urandom_range(2))
        0: return WMAX_L;
        1: return WMIN_L;
        default: return 0;
      endcase
    end
    return longint'($urandom_range(0, 1 << 27)) - (64'sd1 << 26);
  endfunction

  task automatic write_register(cfg_reg_t idx, int unsigned value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[CFG_DATA_W-1:0];
    case (idx)
      CFG_MASS_FIRST:  mass[0] = value & 16'hffff;
      CFG_MASS_SECOND: mass[1] = value & 16'hffff;
      CFG_MASS_THIRD:  mass[2] = value & 16'hffff;
      default:         step_dt = value & 24'hffffff;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Waits for the block to settle; loads cause no result, so a short margin
  // follows the last result.
  task automatic wait_until_quiet();
    while (!(pending_reqs.size() == 0 && !start && expected_snaps.size() == 0 && !busy))
      @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic queue_random_run(int count);
    int queued;
    int order[NBODY];
    queued = 0;
    while (queued < count) begin
      if ($urandom_range(99) < 80) begin
        // Well-formed: all three bodies set up, then a few steps.
        order = '{0, 1, 2};
        order.shuffle();
        foreach (order[k])
          queue_load(order[k], pick_value(1), pick_value(1), pick_value(1), pick_value(1));
        repeat ($urandom_range(1, 4)) begin
          queue_tick();
          queued++;
        end
        queued += NBODY;
      end else if ($urandom_range(1) == 0) begin
        // Stray load, sometimes to the nonexistent fourth slot.
        queue_load($urandom_range(3), pick_value(1), pick_value(1),
                   pick_value(1), pick_value(1));
        queued++;
      end else begin
        queue_tick();
        queued++;
      end
    end
  endtask

  initial begin
    for (int i = 0; i < NBODY; i++) begin
      pos_x[i] = 0;
      pos_y[i] = 0;
      vel_x[i] = 0;
      vel_y[i] = 0;
      mass[i]  = MASS_RESET;
    end
    step_dt = DT_RESET;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset register values.
    queue_tick();                                   // all bodies at the origin
    queue_load(0, 0, 0, 0, 0);
    queue_load(1, UNIT, 0, 0, UNIT / 2);
    queue_load(2, 0, UNIT, -UNIT / 2, 0);
    queue_tick();
    queue_tick();
    queue_load(3, WMAX_L, WMAX_L, WMAX_L, WMAX_L);  // must be ignored
    queue_tick();
    // Separation so small that its square rounds to zero.
    queue_load(1, 1, 0, 0, 0);
    queue_tick();
    // Opposite corners of the word range, with extreme velocities.
    queue_load(0, WMAX_L, WMAX_L, WMAX_L, WMIN_L);
    queue_load(1, WMIN_L, WMIN_L, WMIN_L, WMAX_L);
    queue_load(2, 0, WMIN_L, 0, 0);
    queue_tick();
    queue_tick();
    // Two coincident bodies beside a distant third.
    queue_load(0, UNIT, UNIT, 0, 0);
    queue_load(1, UNIT, UNIT, 0, 0);
    queue_load(2, -100 * UNIT, 3, 0, 0);
    queue_tick();
    wait_until_quiet();

    // Extremes of masses and a dt just below one, with a sender that idles now and then.
    sender_idle_pct = 15;
    write_register(CFG_MASS_FIRST, 0);
    write_register(CFG_MASS_SECOND, 65535);
    write_register(CFG_MASS_THIRD, 1);
    write_register(CFG_TIME_STEP, 24'hffffff);
    queue_random_run(110);
    wait_until_quiet();

    // Heavy bodies and the smallest dt, with a sender that idles often.
    sender_idle_pct = 77;
    write_register(CFG_MASS_FIRST, 65535);
    write_register(CFG_MASS_SECOND, 65535);
    write_register(CFG_MASS_THIRD, 65535);
    write_register(CFG_TIME_STEP, 1);
    queue_random_run(110);
    wait_until_quiet();

    // Random settings, back to back.
    sender_idle_pct = 0;
    write_register(CFG_MASS_FIRST, $urandom_range(65535));
    write_register(CFG_MASS_SECOND, $urandom_range(65535));
    write_register(CFG_MASS_THIRD, $urandom_range(200));
    write_register(CFG_TIME_STEP, $urandom_range(1, 24'hffffff));
    queue_random_run(150);
    wait_until_quiet();

    repeat (50) @(posedge clk);
    if (error_count == 0 && expected_snaps.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
